>>> rtl/core/hmqb_pkg.sv
// ----------------------------------------------------------------------------
// hmqb_pkg
// Shared types and constants of the quadrature mouse bridge.
// ----------------------------------------------------------------------------
package hmqb_pkg;

	localparam int NUM_MAP_REGS = 6;

	localparam logic [31:0] KEY_BASE    = 32'h0000_0010;
	localparam logic [7:0]  RELEASE_BIT = 8'h80;
	localparam logic [31:0] LAST_BUTTON_MAP = 32'd8;

	// Quadrature line levels, indexed by phase
	localparam logic [3:0] LINE_A = 4'b1100;
	localparam logic [3:0] LINE_B = 4'b0110;

	typedef enum logic [2:0] {
		REG_BUTTON0_MAP    = 3'd0,
		REG_BUTTON1_MAP    = 3'd1,
		REG_BUTTON2_MAP    = 3'd2,
		REG_BUTTON3_MAP    = 3'd3,
		REG_BUTTON4_MAP    = 3'd4,
		REG_BUTTON5_MAP    = 3'd5,
		REG_FORCED_BUTTONS = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic       fire_n;
		logic       pot_y_n;
		logic       pot_x_n;
		logic       x_phase_a;
		logic       x_phase_b;
		logic       y_phase_a;
		logic       y_phase_b;
		logic       key_valid;
		logic [7:0] key_code;
		logic       final_item;
	} result_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] idx;
	} pin_sel_t;

	// Resolve a button's map value to one of the three pins, if any
	function automatic pin_sel_t pin_target(input logic [31:0] map_val, input logic [2:0] button);
		logic [31:0] m;
		pin_sel_t    sel;
		if (map_val == 32'd0) begin
			m = {29'd0, button};
		end else if (map_val <= LAST_BUTTON_MAP) begin
			m = map_val - 32'd1;
		end else begin
			m = map_val;
		end
		sel.hit = (m <= 32'd2);
		sel.idx = m[1:0];
		return sel;
	endfunction

endpackage

>>> rtl/core/hmqb_if.sv
// ----------------------------------------------------------------------------
// hmqb_if
// Valid/ready channels of the quadrature mouse bridge: input items and results.
// ----------------------------------------------------------------------------
interface hmqb_in_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic signed [15:0] delta_x;
	logic signed [15:0] delta_y;
	logic [15:0]        button_bits;

	modport source (output valid, output op, output delta_x, output delta_y,
		output button_bits, input ready);
	modport sink (input valid, input op, input delta_x, input delta_y,
		input button_bits, output ready);
endinterface

interface hmqb_out_if;
	logic       valid;
	logic       ready;
	logic       fire_n;
	logic       pot_y_n;
	logic       pot_x_n;
	logic       x_phase_a;
	logic       x_phase_b;
	logic       y_phase_a;
	logic       y_phase_b;
	logic       key_valid;
	logic [7:0] key_code;
	logic       final_item;

	modport source (output valid, output fire_n, output pot_y_n, output pot_x_n,
		output x_phase_a, output x_phase_b, output y_phase_a, output y_phase_b,
		output key_valid, output key_code, output final_item, input ready);
	modport sink (input valid, input fire_n, input pot_y_n, input pot_x_n,
		input x_phase_a, input x_phase_b, input y_phase_a, input y_phase_b,
		input key_valid, input key_code, input final_item, output ready);
endinterface

>>> rtl/core/hmqb_step_unit.sv
// ----------------------------------------------------------------------------
// hmqb_step_unit
// Shared saturating accumulator step: adds a report delta, or moves one
// count toward zero on a tick.
// ----------------------------------------------------------------------------
module hmqb_step_unit #(
	parameter int COUNT_BITS = 17
) (
	input  logic signed [COUNT_BITS-1:0] acc,
	input  logic signed [15:0]           delta,
	input  logic                         tick,
	output logic signed [COUNT_BITS-1:0] sum,
	output logic                         step_up,
	output logic                         step_dn
);

	localparam int SW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

	localparam logic signed [SW-1:0] HI = {{(SW-COUNT_BITS+1){1'b0}}, {(COUNT_BITS-1){1'b1}}};
	localparam logic signed [SW-1:0] LO = {{(SW-COUNT_BITS+1){1'b1}}, {(COUNT_BITS-1){1'b0}}};

	logic signed [SW-1:0] acc_w;
	logic signed [SW-1:0] add_w;
	logic signed [SW-1:0] sum_w;
	logic                 pos;
	logic                 neg;

	assign acc_w = {{(SW-COUNT_BITS){acc[COUNT_BITS-1]}}, acc};
	assign neg   = acc[COUNT_BITS-1];
	assign pos   = !acc[COUNT_BITS-1] && (acc != '0);

	always_comb begin
		priority if (!tick) begin
			add_w = {{(SW-16){delta[15]}}, delta};
		end else if (pos) begin
			add_w = '1;
		end else if (neg) begin
			add_w = SW'(1);
		end else begin
			add_w = '0;
		end
	end

	assign sum_w = acc_w + add_w;

	always_comb begin
		priority if (sum_w > HI) begin
			sum = HI[COUNT_BITS-1:0];
		end else if (sum_w < LO) begin
			sum = LO[COUNT_BITS-1:0];
		end else begin
			sum = sum_w[COUNT_BITS-1:0];
		end
	end

	assign step_dn = tick && pos;
	assign step_up = tick && neg;

endmodule

>>> rtl/core/hmqb_out_reg.sv
// ----------------------------------------------------------------------------
// hmqb_out_reg
// Result holding register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module hmqb_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hmqb_pkg::result_t push_data,
	output logic              free,
	output logic              valid,
	input  logic              ready,
	output hmqb_pkg::result_t data
);

	logic              valid_q;
	hmqb_pkg::result_t data_q;

	assign free  = !valid_q || ready;
	assign valid = valid_q;
	assign data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

endmodule

>>> rtl/core/hid_mouse_to_quadrature_bridge.sv
// ----------------------------------------------------------------------------
// hid_mouse_to_quadrature_bridge
// Turns relative mouse reports and step ticks into button pins, quadrature
// line levels and a keystroke stream.
// ----------------------------------------------------------------------------
// Channels: item (op, delta_x, delta_y, button_bits) and result (pin and
// phase levels, key_valid, key_code, final_item), both valid/ready; a
// transfer happens when valid and ready are high at a clock edge. Map and
// forced-button registers are loaded through wr_en/wr_index/wr_data; the
// user must do so only while the block is idle, and the block itself does not enforce this.
// One item is handled at a time by a sequencer around a single shared
// saturating step unit: X then Y, then the keystroke slots in turn, at
// least one and at most KEYS_PER_BUTTON per mapped button.
// A tick skips the keystroke scan; its single result is pushed from the
// flush state after X and Y. A report scans from min(MAPPED_BUTTONS,6)
// up to min(MAPPED_BUTTONS,6)*KEYS_PER_BUTTON slots, and a result-side
// stall can hold either one back.
// Keystrokes are held one deep so the last one carries final_item; each
// result shows pin and phase levels after the whole item.
// A stalled receiver holds the output register and freezes the scan.
// Reset clears accumulators, phases, press history and maps, and
// releases all pins.
// ----------------------------------------------------------------------------
module hid_mouse_to_quadrature_bridge #(
	parameter int MAPPED_BUTTONS  = 6,
	parameter int KEYS_PER_BUTTON = 4,
	parameter int COUNT_BITS      = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	hmqb_in_if.sink           item,
	hmqb_out_if.source        result,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [31:0]       wr_data
);

	localparam int SCAN = (MAPPED_BUTTONS < hmqb_pkg::NUM_MAP_REGS) ?
		MAPPED_BUTTONS : hmqb_pkg::NUM_MAP_REGS;
	localparam int BW = $clog2(SCAN);
	localparam int KW = (KEYS_PER_BUTTON > 1) ? $clog2(KEYS_PER_BUTTON) : 1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_X     = 5'b00010,
		S_Y     = 5'b00100,
		S_KEY   = 5'b01000,
		S_FLUSH = 5'b10000
	} state_t;

	state_t                       state_q;
	logic                         op_q;
	logic signed [15:0]           dx_q;
	logic signed [15:0]           dy_q;
	logic [SCAN-1:0]              btn_q;
	logic [SCAN-1:0]              prev_q;
	logic [BW-1:0]                b_q;
	logic [KW-1:0]                k_q;
	logic                         pend_valid_q;
	logic [7:0]                   pend_code_q;
	logic signed [COUNT_BITS-1:0] x_count_q;
	logic signed [COUNT_BITS-1:0] y_count_q;
	logic [1:0]                   x_phase_q;
	logic [1:0]                   y_phase_q;
	logic [2:0]                   pins_q;
	logic [31:0]                  map_q [hmqb_pkg::NUM_MAP_REGS];
	logic [15:0]                  forced_q;

	logic                         accept;
	logic [15:0]                  btn_full;
	logic signed [COUNT_BITS-1:0] unit_acc;
	logic signed [15:0]           unit_delta;
	logic signed [COUNT_BITS-1:0] unit_sum;
	logic                         unit_up;
	logic                         unit_dn;
	logic [2:0]                   pins_next;
	hmqb_pkg::pin_sel_t           sel;
	logic [31:0]                  key_map [SCAN];
	logic [31:0]                  m;
	logic [31:0]                  rem;
	logic                         emit;
	logic [7:0]                   key_byte;
	logic                         last_k;
	logic                         last_b;
	logic                         stall;
	logic                         adv_button;
	logic                         out_free;
	logic                         push;
	hmqb_pkg::result_t            push_data;
	hmqb_pkg::result_t            out_data;

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign btn_full   = item.button_bits | forced_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hmqb_pkg::NUM_MAP_REGS; i++) begin
				map_q[i] <= '0;
			end
			forced_q <= '0;
		end else if (wr_en) begin
			if (wr_index < 3'(hmqb_pkg::NUM_MAP_REGS)) begin
				map_q[wr_index] <= wr_data;
			end else if (wr_index == hmqb_pkg::REG_FORCED_BUTTONS) begin
				forced_q <= wr_data[15:0];
			end
		end
	end

	// Shared step unit
	assign unit_acc   = (state_q == S_Y) ? y_count_q : x_count_q;
	assign unit_delta = (state_q == S_Y) ? dy_q : dx_q;

	hmqb_step_unit #(
		.COUNT_BITS (COUNT_BITS)
	) u_step (
		.acc     (unit_acc),
		.delta   (unit_delta),
		.tick    (op_q),
		.sum     (unit_sum),
		.step_up (unit_up),
		.step_dn (unit_dn)
	);

	// Pin routing, highest button wins
	always_comb begin
		pins_next = pins_q;
		sel       = '0;
		for (int b = 0; b < SCAN; b++) begin
			sel = hmqb_pkg::pin_target(map_q[b], 3'(b));
			if (sel.hit) begin
				pins_next[sel.idx] = !btn_q[b];
			end
		end
	end

	// Keystroke slot scan
	always_comb begin
		for (int i = 0; i < SCAN; i++) begin
			key_map[i] = map_q[i];
		end
	end

	assign m        = key_map[b_q];
	assign rem      = (m - hmqb_pkg::KEY_BASE) >> {k_q, 3'b000};
	assign emit     = (m >= hmqb_pkg::KEY_BASE) && (prev_q[b_q] != btn_q[b_q]) && (rem != '0);
	assign key_byte = rem[7:0] | (btn_q[b_q] ? 8'h00 : hmqb_pkg::RELEASE_BIT);
	assign last_k   = (k_q == KW'(KEYS_PER_BUTTON - 1));
	assign last_b   = (b_q == BW'(SCAN - 1));
	assign stall    = emit && pend_valid_q && !out_free;
	assign adv_button = !stall && (!emit || last_k);

	// Result push
	always_comb begin
		push_data.fire_n     = pins_q[0];
		push_data.pot_y_n    = pins_q[1];
		push_data.pot_x_n    = pins_q[2];
		push_data.x_phase_a  = hmqb_pkg::LINE_A[x_phase_q];
		push_data.x_phase_b  = hmqb_pkg::LINE_B[x_phase_q];
		push_data.y_phase_a  = hmqb_pkg::LINE_A[y_phase_q];
		push_data.y_phase_b  = hmqb_pkg::LINE_B[y_phase_q];
		push_data.key_valid  = pend_valid_q;
		push_data.key_code   = pend_valid_q ? pend_code_q : 8'h00;
		push_data.final_item = (state_q == S_FLUSH);
		push = ((state_q == S_KEY) && emit && pend_valid_q && out_free) ||
			((state_q == S_FLUSH) && out_free);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pend_valid_q <= 1'b0;
			pend_code_q  <= '0;
			x_count_q    <= '0;
			y_count_q    <= '0;
			x_phase_q    <= '0;
			y_phase_q    <= '0;
			pins_q       <= 3'b111;
			prev_q       <= '0;
			b_q          <= '0;
			k_q          <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pend_valid_q <= 1'b0;
						b_q          <= '0;
						k_q          <= '0;
						state_q      <= S_X;
					end
				end
				S_X: begin
					x_count_q <= unit_sum;
					if (unit_dn) begin
						x_phase_q <= x_phase_q + 2'd3;
					end else if (unit_up) begin
						x_phase_q <= x_phase_q + 2'd1;
					end
					if (!op_q) begin
						pins_q <= pins_next;
					end
					state_q <= S_Y;
				end
				S_Y: begin
					y_count_q <= unit_sum;
					if (unit_dn) begin
						y_phase_q <= y_phase_q + 2'd3;
					end else if (unit_up) begin
						y_phase_q <= y_phase_q + 2'd1;
					end
					state_q <= op_q ? S_FLUSH : S_KEY;
				end
				S_KEY: begin
					if (!stall) begin
						if (emit) begin
							pend_valid_q <= 1'b1;
							pend_code_q  <= key_byte;
						end
						if (adv_button) begin
							prev_q[b_q] <= btn_q[b_q];
							k_q         <= '0;
							if (last_b) begin
								state_q <= S_FLUSH;
							end else begin
								b_q <= b_q + 1'b1;
							end
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= item.op;
			dx_q  <= item.delta_x;
			dy_q  <= item.delta_y;
			btn_q <= btn_full[SCAN-1:0];
		end
	end

	hmqb_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.free      (out_free),
		.valid     (result.valid),
		.ready     (result.ready),
		.data      (out_data)
	);

	assign result.fire_n     = out_data.fire_n;
	assign result.pot_y_n    = out_data.pot_y_n;
	assign result.pot_x_n    = out_data.pot_x_n;
	assign result.x_phase_a  = out_data.x_phase_a;
	assign result.x_phase_b  = out_data.x_phase_b;
	assign result.y_phase_a  = out_data.y_phase_a;
	assign result.y_phase_b  = out_data.y_phase_b;
	assign result.key_valid  = out_data.key_valid;
	assign result.key_code   = out_data.key_code;
	assign result.final_item = out_data.final_item;

endmodule

>>> rtl/core/hmqb_checker.sv
// ----------------------------------------------------------------------------
// hmqb_checker
// Port-level checks of the quadrature mouse bridge, bound to the top level.
// ----------------------------------------------------------------------------
module hmqb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_key_valid,
	input logic       out_final_item
);

	// Busy after a transfer in
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on back-to-back cycles");

	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A result without a keystroke stands alone
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_key_valid |-> out_final_item)
		else $error("non-key result not marked final");

	// No new item while results of the current one remain
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_final_item |-> !in_ready)
		else $error("input ready before last result");

endmodule

bind hid_mouse_to_quadrature_bridge hmqb_checker u_hmqb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (item.valid),
	.in_ready       (item.ready),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.out_key_valid  (result.key_valid),
	.out_final_item (result.final_item)
);

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for hid_mouse_to_quadrature_bridge. A directed table covers the
// count and pin extremes, shared pins, keystroke mappings and the 24-key
// worst case. Randomized phases follow, each with its own register set.
// Every result transfer is compared against an internal model of the
// accumulators, phases, pins and keystroke stream. Both channels idle at
// random, and one long output stall backs up the input.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MAPPED_BUTTONS  = 6;
	localparam int KEYS_PER_BUTTON = 4;
	localparam int COUNT_BITS      = 17;
	localparam int MAX_RESULTS     = 24;
	localparam int COUNT_MAX       = (1 << (COUNT_BITS - 1)) - 1;
	localparam int COUNT_MIN       = -(1 << (COUNT_BITS - 1));
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int RANDOM_PHASES   = 6;
	localparam int PHASE_ITEMS     = 36;

	typedef enum logic {
		OP_REPORT = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	typedef enum logic {
		ROW_ITEM  = 1'b0,
		ROW_WRITE = 1'b1
	} row_kind_t;

	typedef struct packed {
		op_t                op;
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic [15:0]        button_bits;
	} mouse_item_t;

	typedef struct {
		row_kind_t            kind;
		mouse_item_t          stim;
		hmqb_pkg::reg_idx_t   reg_sel;
		logic [31:0]          reg_val;
		bit                   typed;
		hmqb_pkg::result_t    want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [2:0]  wr_index = '0;
	logic [31:0] wr_data = '0;

	hmqb_in_if  item_ch();
	hmqb_out_if result_ch();

	hid_mouse_to_quadrature_bridge #(
		.MAPPED_BUTTONS  (MAPPED_BUTTONS),
		.KEYS_PER_BUTTON (KEYS_PER_BUTTON),
		.COUNT_BITS      (COUNT_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #2 clk = ~clk;

	// Model state
	logic [31:0] button_map [MAPPED_BUTTONS] = '{default: '0};
	logic [15:0] forced_bits = '0;
	int          x_acc = 0;
	int          y_acc = 0;
	logic [1:0]  x_phase = '0;
	logic [1:0]  y_phase = '0;
	logic [MAPPED_BUTTONS-1:0] prev_press = '0;
	logic [2:0]  pin_levels = 3'b111;

	hmqb_pkg::result_t bridge_outputs[$];
	stim_row_t   directed_rows[$];
	logic [15:0] held_buttons = '0;
	int          mismatches = 0;
	bit          long_hold = 1'b0;
	bit          sender_burst = 1'b0;
	bit          receiver_burst = 1'b0;
	int          quiet_cycles = 0;

	task automatic flag_mismatch(input string what, input hmqb_pkg::result_t got,
		input hmqb_pkg::result_t want);
		$display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic int clamp_count(input int sum);
		if (sum > COUNT_MAX) return COUNT_MAX;
		if (sum < COUNT_MIN) return COUNT_MIN;
		return sum;
	endfunction

	function automatic void mouse_bridge_step(input mouse_item_t it);
		logic [7:0]        keys[$];
		logic [31:0]       m;
		logic [31:0]       v;
		logic [15:0]       btn;
		logic              pressed;
		hmqb_pkg::result_t r;
		if (it.op == OP_TICK) begin
			if (x_acc > 0) begin
				x_acc--;
				x_phase--;
			end else if (x_acc < 0) begin
				x_acc++;
				x_phase++;
			end
			if (y_acc > 0) begin
				y_acc--;
				y_phase--;
			end else if (y_acc < 0) begin
				y_acc++;
				y_phase++;
			end
		end else begin
			btn = it.button_bits | forced_bits;
			x_acc = clamp_count(x_acc + int'(it.delta_x));
			y_acc = clamp_count(y_acc + int'(it.delta_y));
			for (int b = 0; b < MAPPED_BUTTONS; b++) begin
				m = button_map[b];
				pressed = btn[b];
				if (m == 32'd0)
					m = b;
				else if (m <= hmqb_pkg::LAST_BUTTON_MAP)
					m = m - 32'd1;
				if (m <= 32'd2) begin
					pin_levels[m[1:0]] = ~pressed;
				end else if (m >= hmqb_pkg::KEY_BASE && prev_press[b] != pressed) begin
					v = m - hmqb_pkg::KEY_BASE;
					for (int k = 0; k < KEYS_PER_BUTTON && v != 0; k++) begin
						if (keys.size() < MAX_RESULTS)
							keys.push_back(v[7:0] |
								(pressed ? 8'h00 : hmqb_pkg::RELEASE_BIT));
						v = v >> 8;
					end
				end
				prev_press[b] = pressed;
			end
		end
		r = '0;
		r.fire_n    = pin_levels[0];
		r.pot_y_n   = pin_levels[1];
		r.pot_x_n   = pin_levels[2];
		r.x_phase_a = hmqb_pkg::LINE_A[x_phase];
		r.x_phase_b = hmqb_pkg::LINE_B[x_phase];
		r.y_phase_a = hmqb_pkg::LINE_A[y_phase];
		r.y_phase_b = hmqb_pkg::LINE_B[y_phase];
		if (keys.size() == 0) begin
			r.final_item = 1'b1;
			bridge_outputs.push_back(r);
		end else begin
			foreach (keys[k]) begin
				r.key_valid  = 1'b1;
				r.key_code   = keys[k];
				r.final_item = (k == keys.size() - 1);
				bridge_outputs.push_back(r);
			end
		end
	endfunction

	function automatic hmqb_pkg::result_t idle_levels(input logic [2:0] pins_n,
		input logic [1:0] x_ab, input logic [1:0] y_ab);
		hmqb_pkg::result_t r;
		r = '0;
		{r.fire_n, r.pot_y_n, r.pot_x_n} = pins_n;
		{r.x_phase_a, r.x_phase_b} = x_ab;
		{r.y_phase_a, r.y_phase_b} = y_ab;
		r.final_item = 1'b1;
		return r;
	endfunction

	function automatic void add_item(input op_t op, input logic [15:0] dx,
		input logic [15:0] dy, input logic [15:0] btn);
		stim_row_t row;
		row = '{kind: ROW_ITEM, stim: '{op, dx, dy, btn},
			reg_sel: hmqb_pkg::REG_BUTTON0_MAP, reg_val: '0, typed: 1'b0, want: '0};
		directed_rows.push_back(row);
	endfunction

	function automatic void add_checked(input op_t op, input logic [15:0] dx,
		input logic [15:0] dy, input logic [15:0] btn, input hmqb_pkg::result_t want);
		add_item(op, dx, dy, btn);
		directed_rows[directed_rows.size() - 1].typed = 1'b1;
		directed_rows[directed_rows.size() - 1].want  = want;
	endfunction

	function automatic void add_write(input hmqb_pkg::reg_idx_t sel, input logic [31:0] val);
		stim_row_t row;
		row = '{kind: ROW_WRITE, stim: '0, reg_sel: sel, reg_val: val, typed: 1'b0,
			want: '0};
		directed_rows.push_back(row);
	endfunction

	function automatic logic [15:0] random_delta();
		case ($urandom_range(0, 7))
			0: return 16'($urandom);
			1: return 16'h7FFF;
			2: return 16'h8000;
			default: return 16'(int'($urandom_range(0, 16)) - 8);
		endcase
	endfunction

	function automatic mouse_item_t random_item();
		mouse_item_t it;
		it.op      = $urandom_range(0, 1) ? OP_TICK : OP_REPORT;
		it.delta_x = random_delta();
		it.delta_y = random_delta();
		case ($urandom_range(0, 7))
			0: held_buttons = 16'($urandom);
			1: held_buttons = '0;
			default: held_buttons[$urandom_range(0, MAPPED_BUTTONS - 1)] ^= 1'b1;
		endcase
		if ($urandom_range(0, 3) == 0)
			held_buttons[15:MAPPED_BUTTONS] = 10'($urandom);
		it.button_bits = held_buttons;
		return it;
	endfunction

	function automatic logic [31:0] random_map();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'($urandom_range(1, 8));
			2: return 32'($urandom_range(9, 15));
			3: return hmqb_pkg::KEY_BASE + 32'($urandom_range(1, 255));
			4: return hmqb_pkg::KEY_BASE + 32'($urandom_range(1, 32'h00FF_FFFF));
			default: return $urandom;
		endcase
	endfunction

	task automatic write_register(input hmqb_pkg::reg_idx_t sel, input logic [31:0] val);
		wr_en    <= 1'b1;
		wr_index <= sel;
		wr_data  <= val;
		@(posedge clk);
		if (sel == hmqb_pkg::REG_FORCED_BUTTONS)
			forced_bits = val[15:0];
		else
			button_map[sel] = val;
	endtask

	// Drop valid and wait until every pending result has come out
	task automatic settle_idle();
		item_ch.valid <= 1'b0;
		while (bridge_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_item(input mouse_item_t it);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 5);
		if ($urandom_range(0, 15) == 0)
			sender_burst = ~sender_burst;
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.op          <= it.op;
		item_ch.delta_x     <= it.delta_x;
		item_ch.delta_y     <= it.delta_y;
		item_ch.button_bits <= it.button_bits;
		do @(posedge clk); while (!item_ch.ready);
		mouse_bridge_step(it);
	endtask

	task automatic check_result(input hmqb_pkg::result_t got,
		input hmqb_pkg::result_t want);
		if (got !== want)
			flag_mismatch("result", got, want);
	endtask

	// Result side
	initial begin
		hmqb_pkg::result_t got;
		int                gap;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end
			gap = receiver_burst ? 0 : $urandom_range(0, 5);
			if ($urandom_range(0, 15) == 0)
				receiver_burst = ~receiver_burst;
			if (gap != 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			got = '{result_ch.fire_n, result_ch.pot_y_n, result_ch.pot_x_n,
				result_ch.x_phase_a, result_ch.x_phase_b, result_ch.y_phase_a,
				result_ch.y_phase_b, result_ch.key_valid, result_ch.key_code,
				result_ch.final_item};
			if (bridge_outputs.size() == 0)
				flag_mismatch("result with nothing pending", got, '0);
			else
				check_result(got, bridge_outputs.pop_front());
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// Stimulus
	initial begin
		stim_row_t row;
		item_ch.valid       = 1'b0;
		item_ch.op          = 1'b0;
		item_ch.delta_x     = '0;
		item_ch.delta_y     = '0;
		item_ch.button_bits = '0;
		// power-on levels and the signed count extremes, then pins
		add_checked(OP_TICK, 16'h0000, 16'h0000, 16'h0000,
			idle_levels(3'b111, 2'b00, 2'b00));
		add_checked(OP_REPORT, 16'h7FFF, 16'h8000, 16'h0000,
			idle_levels(3'b111, 2'b00, 2'b00));
		add_checked(OP_REPORT, 16'h0000, 16'h0000, 16'h0001,
			idle_levels(3'b011, 2'b00, 2'b00));
		add_checked(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			idle_levels(3'b011, 2'b10, 2'b01));
		add_item(OP_REPORT, 16'h7FFF, 16'h8000, 16'h0000);
		add_item(OP_REPORT, 16'h7FFF, 16'h8000, 16'hFFFF);
		add_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000);
		add_item(OP_REPORT, 16'h8000, 16'h7FFF, 16'h0000);
		// pin remap, single and multi-byte keys, zero byte under a nonzero one
		add_write(hmqb_pkg::REG_BUTTON0_MAP, 32'd1);
		add_write(hmqb_pkg::REG_BUTTON1_MAP, 32'd3);
		add_write(hmqb_pkg::REG_BUTTON2_MAP, hmqb_pkg::KEY_BASE + 32'h41);
		add_write(hmqb_pkg::REG_BUTTON3_MAP, 32'hFFFF_FFFF);
		add_write(hmqb_pkg::REG_BUTTON4_MAP, 32'd9);
		add_write(hmqb_pkg::REG_BUTTON5_MAP, hmqb_pkg::KEY_BASE + 32'h0100_0002);
		add_write(hmqb_pkg::REG_FORCED_BUTTONS, 32'h0000_0000);
		add_item(OP_REPORT, 16'h0001, 16'hFFFF, 16'h003F);
		add_item(OP_REPORT, 16'h0000, 16'h0000, 16'h003F);
		add_item(OP_REPORT, 16'h0000, 16'h0000, 16'h0000);
		// shared pin, empty key value, forced bits incl. an unused one
		add_write(hmqb_pkg::REG_BUTTON0_MAP, 32'd2);
		add_write(hmqb_pkg::REG_BUTTON1_MAP, 32'd2);
		add_write(hmqb_pkg::REG_BUTTON2_MAP, hmqb_pkg::LAST_BUTTON_MAP);
		add_write(hmqb_pkg::REG_BUTTON3_MAP, hmqb_pkg::KEY_BASE);
		add_write(hmqb_pkg::REG_BUTTON4_MAP, 32'd15);
		add_write(hmqb_pkg::REG_BUTTON5_MAP, 32'hFFFF_FFFF);
		add_write(hmqb_pkg::REG_FORCED_BUTTONS, 32'h0000_8021);
		add_item(OP_REPORT, 16'h0000, 16'h0000, 16'h0000);
		add_item(OP_REPORT, 16'h0000, 16'h0000, 16'h0002);
		add_item(OP_REPORT, 16'h0000, 16'h0000, 16'h0000);
		// every button sends four keys: full result burst, then its release
		for (int r = 0; r < MAPPED_BUTTONS; r++)
			add_write(hmqb_pkg::reg_idx_t'(r), 32'hFFFF_FFFF);
		add_write(hmqb_pkg::REG_FORCED_BUTTONS, 32'h0000_003F);
		add_item(OP_REPORT, 16'h0000, 16'h0000, 16'h0000);
		add_write(hmqb_pkg::REG_FORCED_BUTTONS, 32'h0000_0000);
		add_item(OP_REPORT, 16'h0000, 16'h0000, 16'h0000);
		add_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_WRITE) begin
				if (!wr_en)
					settle_idle();
				write_register(row.reg_sel, row.reg_val);
			end else begin
				wr_en <= 1'b0;
				send_item(row.stim);
				if (row.typed)
					bridge_outputs[bridge_outputs.size() - 1] = row.want;
			end
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle_idle();
			for (int r = 0; r < MAPPED_BUTTONS; r++) begin
				if (p == 0)
					write_register(hmqb_pkg::reg_idx_t'(r), 32'd0);
				else if (p == RANDOM_PHASES - 1)
					write_register(hmqb_pkg::reg_idx_t'(r), 32'hFFFF_FFFF);
				else
					write_register(hmqb_pkg::reg_idx_t'(r), random_map());
			end
			if (p == 0)
				write_register(hmqb_pkg::REG_FORCED_BUTTONS, 32'd0);
			else if (p == RANDOM_PHASES - 1)
				write_register(hmqb_pkg::REG_FORCED_BUTTONS, 32'h0000_FFFF);
			else
				write_register(hmqb_pkg::REG_FORCED_BUTTONS,
					{16'd0, 16'($urandom) & ($urandom_range(0, 1) ? 16'hFFC0 : 16'hFFFF)});
			wr_en <= 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 2 && n == 5)
					long_hold = 1'b1;
				send_item(random_item());
			end
		end

		item_ch.valid <= 1'b0;
		while (bridge_outputs.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
